// ===== sv/fcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// fcbp_pkg
// Shared types and constants of the framed command byte parser: register
// indexes, reset values, frame lengths and result kinds.
// ----------------------------------------------------------------------------
package fcbp_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_HEADER_A      = 3'd0,
        CFG_HEADER_B      = 3'd1,
        CFG_FOOTER_A      = 3'd2,
        CFG_FOOTER_B      = 3'd3,
        CFG_TYPE_BRIGHT   = 3'd4,
        CFG_TYPE_BRIGHT_C = 3'd5,
        CFG_TYPE_HIT_CFG  = 3'd6
    } cfg_reg_t;

    // register reset values
    localparam logic [7:0] HEADER_A_RST      = 8'hAA;
    localparam logic [7:0] HEADER_B_RST      = 8'hFD;
    localparam logic [7:0] FOOTER_A_RST      = 8'h55;
    localparam logic [7:0] FOOTER_B_RST      = 8'hFE;
    localparam logic [7:0] TYPE_BRIGHT_RST   = 8'hBF;
    localparam logic [7:0] TYPE_BRIGHT_C_RST = 8'hC0;
    localparam logic [7:0] TYPE_HIT_CFG_RST  = 8'hC1;

    // frame geometry
    localparam logic [3:0] LEN_UNKNOWN = 4'd0;
    localparam logic [3:0] SHORT_LEN   = 4'd5;
    localparam logic [3:0] LONG_LEN    = 4'd13;
    localparam int         BODY_BYTES  = 9;
    localparam int         ROW_BYTES   = 8;
    localparam logic [7:0] BRIGHT_MAX  = 8'd100;

    // result kinds
    typedef enum logic [1:0] {
        KIND_LED       = 2'd0,
        KIND_BRIGHT    = 2'd1,
        KIND_BRIGHT_C  = 2'd2,
        KIND_HIT_CFG   = 2'd3
    } frame_kind_t;

endpackage

// ===== sv/framed_command_byte_parser.sv =====
// ----------------------------------------------------------------------------
// framed_command_byte_parser
// Byte-stream frame parser: hunts for a header, sizes the frame from its type
// byte, checks XOR checksum, footer and brightness range, and emits one
// decoded frame per good frame.
// ----------------------------------------------------------------------------
//  channel  | signals                              | direction | payload
//  ---------+--------------------------------------+-----------+------------------------
//  input    | in_valid / in_ready                  | in        | rx_byte
//  result   | out_valid / out_ready                | out       | frame_kind .. setting_value
//  config   | cfg_we, cfg_index                    | in        | cfg_data (8 bits)
//
//  One byte is taken per cycle while in_ready is high; every byte is fully
//  handled in the cycle of its transfer, and a frame result appears in the
//  output register on the cycle after its footer byte is taken.
//  The output register decouples the sides: input stalls only while a result
//  is held and out_ready is low.
//  Reset (rst_n, asynchronous) returns the parser to header hunt and loads
//  the default header, footer and type codes.
// ----------------------------------------------------------------------------
module framed_command_byte_parser
    import fcbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // byte input
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    // frame result
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  frame_kind,
    output logic        frame_variant,
    output logic [7:0]  led_color,
    output logic [7:0]  led_target,
    output logic [63:0] led_rows,
    output logic [7:0]  setting_value,
    // configuration
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    // configuration registers
    logic [7:0] header_a_reg, header_b_reg, footer_a_reg, footer_b_reg;
    logic [7:0] type_bright_reg, type_bright_c_reg, type_hit_cfg_reg;

    // parser state
    logic [3:0] count_reg, count_next;
    logic [3:0] len_reg, len_next;
    logic       variant_reg, variant_next;
    logic [7:0] type_reg, type_next;
    logic [7:0] xor_reg, xor_next;
    logic [7:0] cks_reg, cks_next;
    logic [7:0] body_reg [BODY_BYTES];
    logic [7:0] body_next [BODY_BYTES];

    // result register
    logic        out_valid_reg, out_valid_next;
    frame_kind_t kind_reg, kind_next;
    logic        res_variant_reg;
    logic [7:0]  color_reg, color_next;
    logic [7:0]  target_reg, target_next;
    logic [63:0] rows_reg, rows_next;
    logic [7:0]  setting_reg, setting_next;

    // decode helpers
    logic        accept;
    logic        hdr_a_hit, hdr_b_hit, hdr_hit;
    logic        short_type;
    logic [3:0]  len_eff;
    logic [7:0]  footer_exp;
    logic        last_byte;
    logic        frame_ok;
    logic        res_load;
    logic [63:0] rows_cat;

    assign accept     = in_valid && in_ready;
    assign in_ready   = !out_valid_reg || out_ready;
    assign hdr_a_hit  = (rx_byte == header_a_reg);
    assign hdr_b_hit  = (rx_byte == header_b_reg);
    assign hdr_hit    = hdr_a_hit || hdr_b_hit;
    assign short_type = (rx_byte == type_bright_reg) || (rx_byte == type_bright_c_reg)
                        || (rx_byte == type_hit_cfg_reg);
    assign len_eff    = (count_reg == 4'd1) ? (short_type ? SHORT_LEN : LONG_LEN) : len_reg;
    assign footer_exp = variant_reg ? footer_b_reg : footer_a_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_a_reg      <= HEADER_A_RST;
            header_b_reg      <= HEADER_B_RST;
            footer_a_reg      <= FOOTER_A_RST;
            footer_b_reg      <= FOOTER_B_RST;
            type_bright_reg   <= TYPE_BRIGHT_RST;
            type_bright_c_reg <= TYPE_BRIGHT_C_RST;
            type_hit_cfg_reg  <= TYPE_HIT_CFG_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HEADER_A:      header_a_reg      <= cfg_data;
                CFG_HEADER_B:      header_b_reg      <= cfg_data;
                CFG_FOOTER_A:      footer_a_reg      <= cfg_data;
                CFG_FOOTER_B:      footer_b_reg      <= cfg_data;
                CFG_TYPE_BRIGHT:   type_bright_reg   <= cfg_data;
                CFG_TYPE_BRIGHT_C: type_bright_c_reg <= cfg_data;
                CFG_TYPE_HIT_CFG:  type_hit_cfg_reg  <= cfg_data;
                default:           ;
            endcase
        end
    end

    // row bytes of an led frame, first row on top
    always_comb
    begin
        for (int i = 0; i < ROW_BYTES; i++)
        begin
            rows_cat[8*(ROW_BYTES-1-i) +: 8] = body_reg[i+1];
        end
    end

    // frame judgement on the footer byte
    always_comb
    begin
        frame_ok  = (cks_reg == xor_reg) && (rx_byte == footer_exp);
        kind_next = KIND_LED;
        if (len_reg == SHORT_LEN)
        begin
            if (type_reg == type_bright_reg)
                kind_next = KIND_BRIGHT;
            else if (type_reg == type_bright_c_reg)
                kind_next = KIND_BRIGHT_C;
            else if (type_reg == type_hit_cfg_reg)
                kind_next = KIND_HIT_CFG;
            else
                frame_ok = 1'b0;
            if (kind_next != KIND_HIT_CFG && body_reg[0] > BRIGHT_MAX)
                frame_ok = 1'b0;
        end
        if (kind_next == KIND_LED)
        begin
            color_next   = type_reg;
            target_next  = body_reg[0];
            rows_next    = rows_cat;
            setting_next = 8'd0;
        end
        else
        begin
            color_next   = 8'd0;
            target_next  = 8'd0;
            rows_next    = 64'd0;
            setting_next = body_reg[0];
        end
    end

    // byte sequencing
    always_comb
    begin
        count_next   = count_reg;
        len_next     = len_reg;
        variant_next = variant_reg;
        type_next    = type_reg;
        xor_next     = xor_reg;
        cks_next     = cks_reg;
        body_next    = body_reg;
        last_byte    = 1'b0;
        if (accept)
        begin
            if ((count_reg == 4'd0 || (count_reg == 4'd1 && len_reg == LEN_UNKNOWN)) && hdr_hit)
            begin
                // header, or a second header before the type byte
                count_next   = 4'd1;
                len_next     = LEN_UNKNOWN;
                variant_next = !hdr_a_hit;
                xor_next     = 8'd0;
            end
            else if (count_reg == 4'd0)
            begin
                // hunting: drop the byte
            end
            else if (count_reg >= len_eff)
            begin
                // out of step: back to hunting
                count_next   = 4'd0;
                len_next     = LEN_UNKNOWN;
                variant_next = 1'b0;
            end
            else
            begin
                if (count_reg == 4'd1)
                begin
                    type_next = rx_byte;
                    len_next  = len_eff;
                end
                if ({1'b0, count_reg} + 5'd3 <= {1'b0, len_eff})
                begin
                    xor_next = xor_reg ^ rx_byte;
                    for (int i = 0; i < BODY_BYTES; i++)
                    begin
                        if (count_reg == 4'(i + 2))
                            body_next[i] = rx_byte;
                    end
                end
                else if ({1'b0, count_reg} + 5'd2 == {1'b0, len_eff})
                begin
                    cks_next = rx_byte;
                end
                if (count_reg + 4'd1 == len_eff)
                begin
                    last_byte    = 1'b1;
                    count_next   = 4'd0;
                    len_next     = LEN_UNKNOWN;
                    variant_next = 1'b0;
                end
                else
                begin
                    count_next = count_reg + 4'd1;
                end
            end
        end
    end

    assign res_load       = last_byte && frame_ok;
    assign out_valid_next = res_load || (out_valid_reg && !out_ready);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= 4'd0;
            len_reg       <= LEN_UNKNOWN;
            variant_reg   <= 1'b0;
            xor_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            len_reg       <= len_next;
            variant_reg   <= variant_next;
            xor_reg       <= xor_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // frame payload
    always_ff @(posedge clk)
    begin
        type_reg <= type_next;
        cks_reg  <= cks_next;
        body_reg <= body_next;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            kind_reg        <= kind_next;
            res_variant_reg <= variant_reg;
            color_reg       <= color_next;
            target_reg      <= target_next;
            rows_reg        <= rows_next;
            setting_reg     <= setting_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign frame_kind    = kind_reg;
    assign frame_variant = res_variant_reg;
    assign led_color     = color_reg;
    assign led_target    = target_reg;
    assign led_rows      = rows_reg;
    assign setting_value = setting_reg;

    // frame length is only ever unknown, short or long
    assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg == LEN_UNKNOWN) || (len_reg == SHORT_LEN) || (len_reg == LONG_LEN))
    else $error("frame length register holds an illegal length");

    // inside a sized frame the byte count stays below the length
    assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg != LEN_UNKNOWN) |-> (count_reg >= 4'd2 && count_reg < len_reg))
    else $error("byte count out of step with frame length");

    // a result is loaded only on the footer byte of a sized frame
    assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (accept && len_reg != LEN_UNKNOWN && count_reg + 4'd1 == len_reg))
    else $error("result loaded away from a footer byte");

    // brightness results never exceed the percent limit
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg == KIND_BRIGHT || kind_reg == KIND_BRIGHT_C))
        |-> (setting_reg <= BRIGHT_MAX))
    else $error("brightness result above limit");

endmodule
